/* hw/rtl/camrc_pkg.sv */
// Package for the camera reply checker: transfer structs, codes and constants.
// Used by camrc_core, camrc_outbuf and camera_reply_checker.
package camrc_pkg;

  // Default reply buffer size in bytes
  localparam int unsigned BUF_BYTES_DEF = 16;

  // Protocol bytes
  localparam logic [7:0] HDR_BROADCAST = 8'h88;
  localparam logic [7:0] TYPE_COMMAND  = 8'h01;
  localparam logic [7:0] TYPE_INQUIRY  = 8'h09;
  localparam logic [7:0] TYPE_ACK      = 8'h40;
  localparam logic [7:0] TYPE_DONE     = 8'h50;
  localparam logic [7:0] TYPE_ERROR    = 8'h60;
  localparam logic [7:0] BYTE_TERM     = 8'hFF;
  localparam logic [7:0] CODE_CANCEL   = 8'h04;
  localparam logic [7:0] TYPE_MASK     = 8'hF0;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_RX    = 1'b1
  } camrc_func_e;

  typedef enum logic [1:0] {
    KIND_BROADCAST = 2'd0,
    KIND_COMMAND   = 2'd1,
    KIND_INQUIRY   = 2'd2
  } camrc_kind_e;

  typedef enum logic [2:0] {
    OUT_ACK        = 3'd0,
    OUT_DONE       = 3'd1,
    OUT_DEVERR     = 3'd2,
    OUT_UNEXPECTED = 3'd3,
    OUT_OVERFLOW   = 3'd4,
    OUT_BADREQ     = 3'd5
  } camrc_outcome_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_WAIT = 2'b10
  } camrc_phase_e;

  typedef struct packed {
    camrc_func_e func;
    logic [7:0]  sent_first;
    logic [7:0]  sent_second;
    logic [7:0]  rx_byte;
  } camrc_in_t;

  typedef struct packed {
    camrc_outcome_e outcome;
    logic [7:0]     reply_type;
    logic [7:0]     err_code;
    logic [4:0]     reply_length;
  } camrc_out_t;

  // Packet type: high nibble, or the whole byte when the high nibble is zero
  function automatic logic [7:0] type_of(input logic [7:0] b);
    logic [7:0] hi;
    hi = b & TYPE_MASK;
    return (hi != 8'h00) ? hi : b;
  endfunction

endpackage

/* hw/rtl/camrc_core.sv */
// Transaction state and reply judging for the camera reply checker.
// Depends on camrc_pkg.
module camrc_core import camrc_pkg::*; #(
  parameter int unsigned BufBytes = BUF_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  camrc_in_t  item_i,
  output logic       res_valid_o,
  output camrc_out_t res_o
);

  localparam int unsigned PosW = $clog2(BufBytes + 2);

  camrc_phase_e   phase_q, phase_d;
  camrc_kind_e    kind_q, kind_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]     first_q, first_d;
  logic [7:0]     second_q, second_d;
  logic [7:0]     third_q, third_d;

  logic [PosW-1:0] pos_inc;
  logic [7:0]      reply_t;
  logic [7:0]      sent_t;
  camrc_outcome_e  judge;

  assign pos_inc = pos_q + PosW'(1);
  assign reply_t = type_of(second_q);
  assign sent_t  = type_of(item_i.sent_second);

  // Judge a finished reply against the pending request
  always_comb begin
    if (reply_t == TYPE_ERROR && third_q != CODE_CANCEL) begin
      judge = OUT_DEVERR;
    end else begin
      case (kind_q)
        KIND_BROADCAST: judge = (first_q == HDR_BROADCAST) ? OUT_DONE : OUT_UNEXPECTED;
        KIND_COMMAND: begin
          if (reply_t == TYPE_ACK)       judge = OUT_ACK;
          else if (reply_t == TYPE_DONE) judge = OUT_DONE;
          else                           judge = OUT_UNEXPECTED;
        end
        default: judge = (reply_t == TYPE_DONE) ? OUT_DONE : OUT_UNEXPECTED;
      endcase
    end
  end

  // Next state and result for the accepted transfer
  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    first_d     = first_q;
    second_d    = second_q;
    third_d     = third_q;
    res_valid_o = 1'b0;
    res_o.outcome      = judge;
    res_o.reply_type   = reply_t;
    res_o.err_code     = third_q;
    res_o.reply_length = 5'(pos_inc);

    if (accept_i) begin
      if (item_i.func == FUNC_START) begin
        // Start: clear the reply and classify the request
        pos_d    = '0;
        first_d  = 8'h00;
        second_d = 8'h00;
        third_d  = 8'h00;
        phase_d  = PH_WAIT;
        if (item_i.sent_first == HDR_BROADCAST) begin
          kind_d = KIND_BROADCAST;
        end else if (sent_t == TYPE_COMMAND) begin
          kind_d = KIND_COMMAND;
        end else if (sent_t == TYPE_INQUIRY) begin
          kind_d = KIND_INQUIRY;
        end else begin
          phase_d            = PH_IDLE;
          res_valid_o        = 1'b1;
          res_o.outcome      = OUT_BADREQ;
          res_o.reply_type   = 8'h00;
          res_o.err_code     = 8'h00;
          res_o.reply_length = 5'd0;
        end
      end else if (phase_q == PH_WAIT) begin
        if (item_i.rx_byte != BYTE_TERM) begin
          // Capture the first three bytes, check for overflow
          if (pos_q == PosW'(0)) first_d  = item_i.rx_byte;
          if (pos_q == PosW'(1)) second_d = item_i.rx_byte;
          if (pos_q == PosW'(2)) third_d  = item_i.rx_byte;
          pos_d = pos_inc;
          if (pos_inc > PosW'(BufBytes)) begin
            phase_d       = PH_IDLE;
            res_valid_o   = 1'b1;
            res_o.outcome = OUT_OVERFLOW;
          end
        end else begin
          // Terminator: report; an ack keeps waiting on a fresh reply
          res_valid_o = 1'b1;
          if (judge == OUT_ACK) begin
            pos_d    = '0;
            first_d  = 8'h00;
            second_d = 8'h00;
            third_d  = 8'h00;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      kind_q   <= KIND_BROADCAST;
      pos_q    <= '0;
      first_q  <= 8'h00;
      second_q <= 8'h00;
      third_q  <= 8'h00;
    end else begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
    end
  end

endmodule

/* hw/rtl/camrc_outbuf.sv */
// Result register with one skid entry for the camera reply checker.
// Depends on camrc_pkg.
module camrc_outbuf import camrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  camrc_out_t data_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output camrc_out_t out_data_o
);

  logic       main_v_q, main_v_d;
  logic       skid_v_q, skid_v_d;
  camrc_out_t main_q, main_d;
  camrc_out_t skid_q, skid_d;
  logic       pop;

  assign pop         = main_v_q && !out_stall_i;
  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  // Advance the main register, park in the skid entry when stalled
  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_d   = data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

/* hw/rtl/camera_reply_checker.sv */
// Camera reply checker top level: request classification and reply judging.
// Output: a transfer's result is registered before it reaches out_data_o, and an output stall can hold it there.
// Throughput: one input transfer per cycle; in_stall_o rises only while a second result
// waits in the skid entry behind a stalled result register.
// Reset: asynchronous, active low; leaves the block idle with an empty reply.
// Depends on camrc_pkg, camrc_core and camrc_outbuf.
module camera_reply_checker import camrc_pkg::*; #(
  parameter int unsigned BufBytes = BUF_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  camrc_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output camrc_out_t out_data_o
);

  logic       accept;
  logic       res_valid;
  camrc_out_t res;
  logic       buf_full;

  // Accept whenever the skid entry is free
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  camrc_core #(
    .BufBytes(BufBytes)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  camrc_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .data_i     (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
